// ===== hw/rtl/mns_pkg.sv =====
// ----------------------------------------------------------------------------
// mns_pkg
// Shared types and constants for the melody note sequencer: table geometry,
// field widths, configuration register indexes and the control state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mns_pkg;

	// note table geometry
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;

	// field widths
	localparam int TIME_W   = 32;
	localparam int WHOLE_W  = 16;
	localparam int COUNT_W  = 7;
	localparam int FREQ_W   = 13;
	localparam int DIV_W    = 6;
	localparam int LEN_W    = 17;
	localparam int DREM_W   = 5;
	localparam int DSTEP_W  = $clog2(WHOLE_W);

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = WHOLE_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WHOLE_NOTE = 1'b0,
		REG_NOTE_COUNT = 1'b1
	} cfg_reg_t;

	// register reset values
	localparam logic [WHOLE_W-1:0] WHOLE_NOTE_RST = WHOLE_W'(1200);
	localparam logic [COUNT_W-1:0] NOTE_COUNT_RST = COUNT_W'(1);

	// one table entry
	typedef struct packed {
		logic        [FREQ_W-1:0] freq;
		logic signed [DIV_W-1:0]  div;
	} note_entry_t;

	// sequencer control states
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_CALC = 4'b1000
	} seq_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/melody_note_sequencer.sv =====
// ----------------------------------------------------------------------------
// melody_note_sequencer
// Tick-driven tone sequencer over a loadable note table: works out the length
// of the current note, the tone gate and the advance to the next note.
// Flow: a tick passes through READ, the 16-step serial divider in DIV (skipped
//   when the note divider is zero) and CALC, then strobes done.
// Throughput: one load per cycle while not busy; no new tick until done.
// Reset: clears the table (per-entry valid bits), note pointer, timer, length
//   and configuration registers at once; no clearing pass. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module melody_note_sequencer (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// command channel
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                req_type,
	input  wire logic [mns_pkg::TIME_W-1:0]          now_ms,
	input  wire logic [mns_pkg::IDX_W-1:0]           entry_index,
	input  wire logic [mns_pkg::FREQ_W-1:0]          entry_freq,
	input  wire logic signed [mns_pkg::DIV_W-1:0]    entry_divider,
	// configuration port
	input  wire logic                                cfg_we,
	input  wire logic [mns_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [mns_pkg::CFG_DATA_W-1:0]      cfg_data,
	// result channel
	output logic                                     done,
	output logic [mns_pkg::FREQ_W-1:0]               freq_hz,
	output logic                                     tone_on,
	output logic [mns_pkg::IDX_W-1:0]                note_index,
	output logic                                     note_advanced
);

	mns_pkg::seq_state_t state_q;

	logic [mns_pkg::WHOLE_W-1:0]     whole_note_q;
	logic [mns_pkg::COUNT_W-1:0]     note_count_q;

	mns_pkg::note_entry_t            mem [mns_pkg::TABLE_DEPTH];
	logic [mns_pkg::TABLE_DEPTH-1:0] valid_q;
	mns_pkg::note_entry_t            rd_data_s1;
	logic                            rd_valid_s1;
	mns_pkg::note_entry_t            entry;

	logic [mns_pkg::IDX_W-1:0]       cur_q;
	logic [mns_pkg::TIME_W-1:0]      start_ms_q;
	logic [mns_pkg::LEN_W-1:0]       len_q;
	logic [mns_pkg::TIME_W-1:0]      now_q;
	logic [mns_pkg::TIME_W-1:0]      elapsed_q;
	logic [mns_pkg::FREQ_W-1:0]      freq_q;

	logic [mns_pkg::DIV_W-1:0]       mag_q;
	logic                            dotted_q;
	logic [mns_pkg::DREM_W-1:0]      rem_q;
	logic [mns_pkg::WHOLE_W-1:0]     quot_q;
	logic [mns_pkg::DSTEP_W-1:0]     step_q;

	logic                            accept;
	logic                            load_wr;
	logic [mns_pkg::DIV_W-1:0]       shifted;
	logic [mns_pkg::DIV_W-1:0]       diff;
	logic                            ge;
	logic [mns_pkg::DREM_W-1:0]      rem_next;
	logic [mns_pkg::WHOLE_W-1:0]     quot_next;
	logic [mns_pkg::LEN_W:0]         len_x3;
	logic [mns_pkg::LEN_W-1:0]       len_div;
	logic [mns_pkg::TIME_W+4:0]      e20;
	logic [mns_pkg::LEN_W+4:0]       l17;
	logic                            tone;
	logic                            adv;
	logic [mns_pkg::COUNT_W-1:0]     eff_count;
	logic [mns_pkg::CNT_W-1:0]       nxt;
	logic [mns_pkg::IDX_W-1:0]       next_note;

	// command handshake
	assign busy    = (state_q != mns_pkg::ST_IDLE);
	assign accept  = start && !busy;
	assign load_wr = accept && req_type;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			whole_note_q <= mns_pkg::WHOLE_NOTE_RST;
			note_count_q <= mns_pkg::NOTE_COUNT_RST;
		end else if (cfg_we) begin
			case (mns_pkg::cfg_reg_t'(cfg_index))
				mns_pkg::REG_WHOLE_NOTE: whole_note_q <= cfg_data;
				mns_pkg::REG_NOTE_COUNT: note_count_q <= cfg_data[mns_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// note table memory, registered read of the current note
	always_ff @(posedge clk) begin
		if (load_wr) begin
			mem[entry_index] <= '{freq: entry_freq, div: entry_divider};
		end
		rd_data_s1 <= mem[cur_q];
	end

	// per-entry valid bits, an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (load_wr) begin
				valid_q[entry_index] <= 1'b1;
			end
			rd_valid_s1 <= valid_q[cur_q];
		end
	end

	assign entry = rd_valid_s1 ? rd_data_s1 : '0;

	// one restoring division step
	assign shifted   = {rem_q, quot_q[mns_pkg::WHOLE_W-1]};
	assign ge        = (shifted >= mag_q);
	assign diff      = shifted - mag_q;
	assign rem_next  = ge ? diff[mns_pkg::DREM_W-1:0] : shifted[mns_pkg::DREM_W-1:0];
	assign quot_next = {quot_q[mns_pkg::WHOLE_W-2:0], ge};

	// length from the finished quotient, dotted notes take 3/2
	assign len_x3  = {2'b00, quot_next} + {1'b0, quot_next, 1'b0};
	assign len_div = dotted_q ? len_x3[mns_pkg::LEN_W:1] : {1'b0, quot_next};

	// tone gate and advance test
	assign e20  = {1'b0, elapsed_q, 4'b0000} + {3'b000, elapsed_q, 2'b00};
	assign l17  = {1'b0, len_q, 4'b0000} + {5'b00000, len_q};
	assign tone = {15'd0, l17} > e20;
	assign adv  = elapsed_q >= {15'd0, len_q};

	// next note with wrap at the effective count
	always_comb begin
		eff_count = note_count_q;
		if (note_count_q == '0) begin
			eff_count = mns_pkg::COUNT_W'(1);
		end else if (note_count_q > mns_pkg::COUNT_W'(mns_pkg::TABLE_DEPTH)) begin
			eff_count = mns_pkg::COUNT_W'(mns_pkg::TABLE_DEPTH);
		end
		nxt       = {1'b0, cur_q} + mns_pkg::CNT_W'(1);
		next_note = (nxt >= mns_pkg::CNT_W'(eff_count)) ? '0 : nxt[mns_pkg::IDX_W-1:0];
	end

	// sequencer control and note state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mns_pkg::ST_IDLE;
			cur_q      <= '0;
			start_ms_q <= '0;
			len_q      <= '0;
			done       <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				mns_pkg::ST_IDLE: begin
					if (accept && !req_type) begin
						state_q <= mns_pkg::ST_READ;
					end
				end
				mns_pkg::ST_READ: begin
					if (entry.div == '0) begin
						state_q <= mns_pkg::ST_CALC;
					end else begin
						state_q <= mns_pkg::ST_DIV;
					end
				end
				mns_pkg::ST_DIV: begin
					if (step_q == '0) begin
						len_q   <= len_div;
						state_q <= mns_pkg::ST_CALC;
					end
				end
				mns_pkg::ST_CALC: begin
					done <= 1'b1;
					if (adv) begin
						cur_q      <= next_note;
						start_ms_q <= now_q;
					end
					state_q <= mns_pkg::ST_IDLE;
				end
				default: state_q <= mns_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath registers for the transaction in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q     <= now_ms;
			elapsed_q <= now_ms - start_ms_q;
		end
		case (state_q)
			mns_pkg::ST_READ: begin
				freq_q   <= entry.freq;
				dotted_q <= entry.div[mns_pkg::DIV_W-1];
				mag_q    <= entry.div[mns_pkg::DIV_W-1] ? mns_pkg::DIV_W'(-entry.div)
				                                        : mns_pkg::DIV_W'(entry.div);
				rem_q    <= '0;
				quot_q   <= whole_note_q;
				step_q   <= mns_pkg::DSTEP_W'(mns_pkg::WHOLE_W - 1);
			end
			mns_pkg::ST_DIV: begin
				rem_q  <= rem_next;
				quot_q <= quot_next;
				step_q <= step_q - mns_pkg::DSTEP_W'(1);
			end
			mns_pkg::ST_CALC: begin
				freq_hz       <= freq_q;
				tone_on       <= tone;
				note_advanced <= adv;
				note_index    <= adv ? next_note : cur_q;
			end
			default: ;
		endcase
	end

	// checks
	a_done_after_calc: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == mns_pkg::ST_CALC))
		else $error("result strobe without a finished calculation");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy while a result is shown");

	a_note_moves_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cur_q) |-> (done && note_advanced))
		else $error("note pointer changed without an advance");

	a_result_index: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (note_index == cur_q))
		else $error("reported note index differs from the note pointer");

endmodule

`default_nettype wire
